FILE: src/cfct_pkg.sv
// ============================================================================
// cfct_pkg: shared definitions for the credit flow control table
// Field widths, request kinds, register indexes, reset values and the
// saturating add used on the credit counters.
// ============================================================================
package cfct_pkg;

    // default table dimensions
    localparam int PEERS_DEF = 16;
    localparam int VCS_DEF   = 4;

    // field widths
    localparam int KIND_W    = 3;
    localparam int PEER_W    = 4;
    localparam int VC_W      = 2;
    localparam int CNT_W     = 16;
    localparam int NVC_W     = 3;
    localparam int CFG_IDX_W = 3;

    // stream payload widths (data widths padded to whole bytes)
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = KIND_W;
    localparam int OUT_DATA_W = 72;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ADD_PEER     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CONSUME      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD_CREDITS  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RECEIVE      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CREDIT_RET   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CREDIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CREDITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VCS      = 3'd6;

    // configuration reset values
    localparam logic [CNT_W-1:0] RST_BASE_CREDIT  = 16'd1;
    localparam logic [CNT_W-1:0] RST_BYTES_PER_CR = 16'd256;
    localparam logic [CNT_W-1:0] RST_BATCH_SIZE   = 16'd1;
    localparam logic [CNT_W-1:0] RST_INIT_CREDITS = 16'd20;
    localparam logic [NVC_W-1:0] RST_NUM_VCS      = 3'd4;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // output tdata bit positions
    localparam int OUT_OK_LSB     = 0;
    localparam int OUT_NEED_LSB   = 1;
    localparam int OUT_TX_LSB     = 17;
    localparam int OUT_PEND_LSB   = 33;
    localparam int OUT_SEND_LSB   = 49;
    localparam int OUT_SENT_LSB   = 50;

    // saturating add of two counters
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

FILE: src/credit_flow_control_table.sv
// ============================================================================
// credit_flow_control_table: per peer and virtual channel credit accounting
// Transmit and return credit counters for each entry, packet cost from a
// shared divider in dynamic mode, credit return batching.
// ============================================================================
// After reset the block clears its entry table, one entry per cycle, and
// takes no request meanwhile; configuration writes are taken at any time.
// It then handles one request at a time: each passes through the execute
// and push states, and a packet request in dynamic mode first waits in the
// divide state, since its cost comes from a shared divider that produces
// one quotient bit per cycle. Add peer then writes the channels it loads
// one at a time, because the table has a single write port. A finished
// result waits in the output register while the next request is taken.
module credit_flow_control_table #(
    parameter int PEERS = cfct_pkg::PEERS_DEF,
    parameter int VCS   = cfct_pkg::VCS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request: peer[3:0], vc[5:4], packet_size[21:6], credits[37:22]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cfct_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [cfct_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // result: ok[0], credits_needed[16:1], tx_credits[32:17],
    // pending_return[48:33], send_credit[49], credits_sent[65:50]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cfct_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfct_pkg::CNT_W-1:0]        cfg_data
);
    import cfct_pkg::*;

    localparam int ENTRIES = PEERS * VCS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VCNT_W  = $clog2(VCS + 1);
    localparam int ENTRY_W = 2 * CNT_W + 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_PEER  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;

    // configuration registers
    logic             link_enable_reg;
    logic             dynamic_mode_reg;
    logic [CNT_W-1:0] base_credit_reg;
    logic [CNT_W-1:0] bytes_per_credit_reg;
    logic [CNT_W-1:0] batch_size_reg;
    logic [CNT_W-1:0] initial_credits_reg;
    logic [NVC_W-1:0] num_vcs_reg;

    // request fields
    logic [KIND_W-1:0] kind_in;
    logic [PEER_W-1:0] peer_in;
    logic [VC_W-1:0]   vc_in;
    logic [CNT_W-1:0]  size_in;
    logic [CNT_W-1:0]  credits_in;
    logic              inside_in;
    logic [IDX_W-1:0]  idx_in;
    logic              in_fire;
    logic              pkt_kind_in;

    logic [KIND_W-1:0] kind_reg;
    logic [PEER_W-1:0] peer_reg;
    logic [VC_W-1:0]   vc_reg;
    logic [CNT_W-1:0]  credits_reg;
    logic              inside_reg;
    logic [IDX_W-1:0]  idx_reg;

    // table
    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   clr_addr_reg;

    // add peer sweep
    logic [VCNT_W-1:0] vcnt_reg;
    logic [VCNT_W-1:0] lim_reg;
    logic [VCNT_W-1:0] lim;
    logic [CNT_W-1:0]  load_reg;
    logic [CNT_W-1:0]  load;

    // divider
    logic             div_start;
    logic             div_done;
    logic [CNT_W-1:0] div_quot;

    // exec datapath
    logic             ent_valid;
    logic [CNT_W-1:0] ent_tx;
    logic [CNT_W-1:0] ent_ret;
    logic             pkt_kind;
    logic [CNT_W-1:0] needed;
    logic             grant;
    logic             exec_ok;
    logic [CNT_W-1:0] exec_tx;
    logic [CNT_W-1:0] exec_pend;
    logic             exec_send;
    logic [CNT_W-1:0] exec_sent;

    // result and output registers
    logic             res_ok_reg;
    logic [CNT_W-1:0] res_need_reg;
    logic [CNT_W-1:0] res_tx_reg;
    logic [CNT_W-1:0] res_pend_reg;
    logic             res_send_reg;
    logic [CNT_W-1:0] res_sent_reg;
    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic             out_load;

    // request unpacking
    assign kind_in    = s_axis_tuser[KIND_W-1:0];
    assign peer_in    = s_axis_tdata[3:0];
    assign vc_in      = s_axis_tdata[5:4];
    assign size_in    = s_axis_tdata[21:6];
    assign credits_in = s_axis_tdata[37:22];
    assign inside_in  = (int'(peer_in) < PEERS) && (int'(vc_in) < VCS);
    assign idx_in     = inside_in ? IDX_W'(int'(peer_in) * VCS + int'(vc_in)) : '0;
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign pkt_kind_in = (kind_in == KIND_CONSUME) || (kind_in == KIND_CHECK) ||
                         (kind_in == KIND_RECEIVE);
    assign div_start  = in_fire && pkt_kind_in && dynamic_mode_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enable_reg      <= 1'b0;
            dynamic_mode_reg     <= 1'b1;
            base_credit_reg      <= RST_BASE_CREDIT;
            bytes_per_credit_reg <= RST_BYTES_PER_CR;
            batch_size_reg       <= RST_BATCH_SIZE;
            initial_credits_reg  <= RST_INIT_CREDITS;
            num_vcs_reg          <= RST_NUM_VCS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LINK_ENABLE:  link_enable_reg      <= cfg_data[0];
                CFG_DYNAMIC_MODE: dynamic_mode_reg     <= cfg_data[0];
                CFG_BASE_CREDIT:  base_credit_reg      <= cfg_data;
                CFG_BYTES_PER_CR: bytes_per_credit_reg <= cfg_data;
                CFG_BATCH_SIZE:   batch_size_reg       <= cfg_data;
                CFG_INIT_CREDITS: initial_credits_reg  <= cfg_data;
                CFG_NUM_VCS:      num_vcs_reg          <= cfg_data[NVC_W-1:0];
                default:          ;
            endcase
        end
    end

    // shared cost divider
    cfct_ceil_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (size_in),
        .divisor  (bytes_per_credit_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg    <= kind_in;
            peer_reg    <= peer_in;
            vc_reg      <= vc_in;
            credits_reg <= credits_in;
            inside_reg  <= inside_in;
            idx_reg     <= idx_in;
        end
    end

    // entry table, read at accept
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[idx_in];
        end
    end

    assign ent_valid = rd_data_reg[ENTRY_W-1];
    assign ent_tx    = rd_data_reg[2*CNT_W-1:CNT_W];
    assign ent_ret   = rd_data_reg[CNT_W-1:0];

    // packet cost
    assign pkt_kind = (kind_reg == KIND_CONSUME) || (kind_reg == KIND_CHECK) ||
                      (kind_reg == KIND_RECEIVE);
    always_comb
    begin
        if (!pkt_kind)
        begin
            needed = '0;
        end
        else if (dynamic_mode_reg && (div_quot >= base_credit_reg))
        begin
            needed = div_quot;
        end
        else
        begin
            needed = base_credit_reg;
        end
    end

    // add peer amount and channel count
    assign load = (credits_reg != '0) ? credits_reg : initial_credits_reg;
    assign lim  = (int'(num_vcs_reg) < VCS) ? VCNT_W'(num_vcs_reg) : VCNT_W'(VCS);
    assign grant = ent_valid && (ent_tx >= needed);

    // entry update and result
    always_comb
    begin
        exec_ok   = 1'b0;
        exec_tx   = ent_tx;
        exec_pend = ent_ret;
        exec_send = 1'b0;
        exec_sent = '0;
        case (kind_reg)
            KIND_ADD_PEER:
            begin
                if (int'(vc_reg) < int'(lim))
                begin
                    exec_tx   = load;
                    exec_pend = '0;
                end
            end
            KIND_CONSUME:
            begin
                exec_ok = grant;
                if (grant)
                begin
                    exec_tx = ent_tx - needed;
                end
            end
            KIND_CHECK:
            begin
                exec_ok = grant;
            end
            KIND_ADD_CREDITS:
            begin
                exec_tx = sat_add(ent_tx, credits_reg);
            end
            KIND_RECEIVE:
            begin
                if (link_enable_reg)
                begin
                    exec_pend = sat_add(ent_ret, needed);
                end
            end
            KIND_CREDIT_RET:
            begin
                if (link_enable_reg && (ent_ret >= batch_size_reg))
                begin
                    exec_send = 1'b1;
                    exec_sent = ent_ret;
                    exec_pend = '0;
                end
            end
            default: ;
        endcase
        if (!inside_reg)
        begin
            exec_ok   = 1'b0;
            exec_tx   = '0;
            exec_pend = '0;
            exec_send = 1'b0;
            exec_sent = '0;
        end
    end

    // table write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {1'b1, exec_tx, exec_pend};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_EXEC:
            begin
                if (inside_reg)
                begin
                    case (kind_reg)
                        KIND_CONSUME:     mem_we = grant;
                        KIND_ADD_CREDITS: mem_we = (credits_reg != '0);
                        KIND_RECEIVE:     mem_we = link_enable_reg;
                        KIND_CREDIT_RET:  mem_we = exec_send;
                        default:          mem_we = 1'b0;
                    endcase
                    mem_wdata = {ent_valid | (kind_reg == KIND_ADD_CREDITS),
                                 exec_tx, exec_pend};
                end
            end
            ST_PEER:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(int'(peer_reg) * VCS + int'(vcnt_reg));
                mem_wdata = {1'b1, load_reg, {CNT_W{1'b0}}};
            end
            default: ;
        endcase
    end

    // sequencer next state
    assign out_load = (state_reg == ST_PUSH) && (!out_valid_reg || m_axis_tready);
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = div_start ? ST_DIV : ST_EXEC;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (inside_reg && (kind_reg == KIND_ADD_PEER) && (lim != '0))
                begin
                    state_next = ST_PEER;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PEER:
            begin
                if (vcnt_reg == lim_reg - 1'b1)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            vcnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == ST_EXEC)
            begin
                vcnt_reg <= '0;
            end
            else if (state_reg == ST_PEER)
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            lim_reg      <= lim;
            load_reg     <= load;
            res_ok_reg   <= exec_ok;
            res_need_reg <= needed;
            res_tx_reg   <= exec_tx;
            res_pend_reg <= exec_pend;
            res_send_reg <= exec_send;
            res_sent_reg <= exec_sent;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{(OUT_DATA_W - OUT_SENT_LSB - CNT_W){1'b0}},
                             res_sent_reg, res_send_reg, res_pend_reg,
                             res_tx_reg, res_need_reg, res_ok_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("table written while idle");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_sent_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_SEND_LSB])
            |-> (m_axis_tdata[OUT_SENT_LSB +: CNT_W] == '0))
        else $error("credit count carried without a return message");

    a_ok_send_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[OUT_OK_LSB] && m_axis_tdata[OUT_SEND_LSB]))
        else $error("grant and credit return in one result");

endmodule

FILE: src/cfct_ceil_div.sv
// ============================================================================
// cfct_ceil_div: iterative rounded-up divider
// Restoring division, one quotient bit per cycle; the quotient is rounded
// up when a remainder is left. A zero divisor counts as one.
// ============================================================================
module cfct_ceil_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cfct_pkg::CNT_W-1:0] dividend,
    input  logic [cfct_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [cfct_pkg::CNT_W-1:0] quotient
);
    import cfct_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]       rem_reg;
    logic [CNT_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     div_reg;
    logic [CNT_W:0]       rem_shift;
    logic                 fits;

    // one restoring step
    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[CNT_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out of quo_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= (divisor == '0) ? CNT_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            quo_reg <= {quo_reg[CNT_W-2:0], fits};
        end
    end

    // round up on a nonzero remainder; cannot overflow
    assign quotient = quo_reg + CNT_W'(rem_reg != '0);
    assign done     = done_reg;

endmodule

FILE: tb/sv/credit_table_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// credit_table_checker: result checker for the credit flow control table
// Watches the request, result and configuration channels, keeps its own
// copy of the credit tables and settings, works out the result of every
// accepted request and compares it field by field with what comes out.
// ============================================================================
module credit_table_checker #(
    parameter int PEERS = cfct_pkg::PEERS_DEF,
    parameter int VCS   = cfct_pkg::VCS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [cfct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [cfct_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [cfct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cfct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfct_pkg::CNT_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import cfct_pkg::*;

    localparam int ENTRIES = PEERS * VCS;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] credits_needed;
        logic [CNT_W-1:0] tx_credits;
        logic [CNT_W-1:0] pending_return;
        logic             send_credit;
        logic [CNT_W-1:0] credits_sent;
    } credit_result_t;

    // shadow copy of the credit tables
    logic [CNT_W-1:0] tx_table     [ENTRIES];
    logic [CNT_W-1:0] return_table [ENTRIES];
    logic             entry_live   [ENTRIES];

    // shadow copy of the settings
    logic             link_enable;
    logic             dynamic_mode;
    logic [CNT_W-1:0] base_credit;
    logic [CNT_W-1:0] bytes_per_credit;
    logic [CNT_W-1:0] batch_size;
    logic [CNT_W-1:0] initial_credits;
    logic [NVC_W-1:0] num_vcs;

    credit_result_t expected_results[$];
    credit_result_t want;
    credit_result_t got;

    // cost of one packet, size rounded up to whole credits
    function automatic logic [CNT_W-1:0] packet_cost(input logic [CNT_W-1:0] size);
        logic [31:0] divisor;
        logic [31:0] cost;
        if (!dynamic_mode)
            return base_credit;
        // a zero divisor counts as one byte per credit
        divisor = (bytes_per_credit == '0) ? 32'd1 : {16'd0, bytes_per_credit};
        cost = ({16'd0, size} + divisor - 32'd1) / divisor;
        return (cost < {16'd0, base_credit}) ? base_credit : cost[CNT_W-1:0];
    endfunction

    // counter addition that sticks at all ones
    function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [CNT_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[CNT_W] ? {CNT_W{1'b1}} : total[CNT_W-1:0];
    endfunction

    // apply one request to the shadow tables and build its result
    function automatic credit_result_t predict_credit_result(
        input logic [KIND_W-1:0] kind,
        input logic [PEER_W-1:0] peer,
        input logic [VC_W-1:0]   vc,
        input logic [CNT_W-1:0]  size,
        input logic [CNT_W-1:0]  amount
    );
        credit_result_t   res;
        int               idx;
        int               lanes;
        int               slot;
        logic [CNT_W-1:0] load;
        res = '0;
        idx = int'(peer) * VCS + int'(vc);
        if (kind == KIND_CONSUME || kind == KIND_CHECK || kind == KIND_RECEIVE)
            res.credits_needed = packet_cost(size);
        // out-of-range entries keep every field but the cost at zero
        if (int'(peer) >= PEERS || int'(vc) >= VCS)
            return res;
        case (kind)
            KIND_ADD_PEER:
            begin
                load = (amount != '0) ? amount : initial_credits;
                lanes = (int'(num_vcs) < VCS) ? int'(num_vcs) : VCS;
                for (int v = 0; v < lanes; v++)
                begin
                    slot = int'(peer) * VCS + v;
                    tx_table[slot] = load;
                    return_table[slot] = '0;
                    entry_live[slot] = 1'b1;
                end
            end
            KIND_CONSUME:
            begin
                if (entry_live[idx] && tx_table[idx] >= res.credits_needed)
                begin
                    tx_table[idx] = tx_table[idx] - res.credits_needed;
                    res.ok = 1'b1;
                end
            end
            KIND_CHECK:
            begin
                res.ok = entry_live[idx] && tx_table[idx] >= res.credits_needed;
            end
            KIND_ADD_CREDITS:
            begin
                // a zero grant leaves the entry untouched
                if (amount != '0)
                begin
                    tx_table[idx] = add_clamped(tx_table[idx], amount);
                    entry_live[idx] = 1'b1;
                end
            end
            KIND_RECEIVE:
            begin
                if (link_enable)
                    return_table[idx] = add_clamped(return_table[idx], res.credits_needed);
            end
            KIND_CREDIT_RET:
            begin
                if (link_enable && return_table[idx] >= batch_size)
                begin
                    res.send_credit = 1'b1;
                    res.credits_sent = return_table[idx];
                    return_table[idx] = '0;
                end
            end
            default:
            begin
            end
        endcase
        res.tx_credits = tx_table[idx];
        res.pending_return = return_table[idx];
        return res;
    endfunction

    // report one field that differs
    task automatic compare_field(input string field, input logic [CNT_W-1:0] exp_val,
                                 input logic [CNT_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            fail_count = fail_count + 1;
        end
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tx_table[i] = '0;
                return_table[i] = '0;
                entry_live[i] = 1'b0;
            end
            link_enable = 1'b0;
            dynamic_mode = 1'b1;
            base_credit = 16'd1;
            bytes_per_credit = 16'd256;
            batch_size = 16'd1;
            initial_credits = 16'd20;
            num_vcs = 3'd4;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            // result first: it always belongs to an older request
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ok             = m_axis_tdata[OUT_OK_LSB];
                got.credits_needed = m_axis_tdata[OUT_NEED_LSB +: CNT_W];
                got.tx_credits     = m_axis_tdata[OUT_TX_LSB +: CNT_W];
                got.pending_return = m_axis_tdata[OUT_PEND_LSB +: CNT_W];
                got.send_credit    = m_axis_tdata[OUT_SEND_LSB];
                got.credits_sent   = m_axis_tdata[OUT_SENT_LSB +: CNT_W];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("ok", CNT_W'(want.ok), CNT_W'(got.ok));
                    compare_field("credits_needed", want.credits_needed, got.credits_needed);
                    compare_field("tx_credits", want.tx_credits, got.tx_credits);
                    compare_field("pending_return", want.pending_return, got.pending_return);
                    compare_field("send_credit", CNT_W'(want.send_credit),
                                  CNT_W'(got.send_credit));
                    compare_field("credits_sent", want.credits_sent, got.credits_sent);
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINK_ENABLE:  link_enable = cfg_data[0];
                    CFG_DYNAMIC_MODE: dynamic_mode = cfg_data[0];
                    CFG_BASE_CREDIT:  base_credit = cfg_data;
                    CFG_BYTES_PER_CR: bytes_per_credit = cfg_data;
                    CFG_BATCH_SIZE:   batch_size = cfg_data;
                    CFG_INIT_CREDITS: initial_credits = cfg_data;
                    CFG_NUM_VCS:      num_vcs = cfg_data[NVC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // new request
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_credit_result(
                    s_axis_tuser,
                    s_axis_tdata[3:0],
                    s_axis_tdata[5:4],
                    s_axis_tdata[21:6],
                    s_axis_tdata[37:22]));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus for the credit flow control table
// Drives directed and random requests under several register settings with
// random gaps on both streams and one long hold-off on the result side;
// the checker beside the block predicts and compares every result.
// ============================================================================
module testbench;
    import cfct_pkg::*;

    // kinds the block does not define
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_STALL   = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CNT_W-1:0]      cfg_data;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   src_idle_pct = 12;
    int   sink_idle_pct = 58;
    logic stall_trigger = 1'b0;
    logic stall_started;
    int   stall_left;

    credit_flow_control_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    credit_table_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        stall_started = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_trigger && !stall_started)
            begin
                stall_started = 1'b1;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
                m_axis_tready = (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [PEER_W-1:0] peer,
                                input logic [VC_W-1:0] vc, input logic [CNT_W-1:0] size,
                                input logic [CNT_W-1:0] amount);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, amount, size, vc, peer};
        s_axis_tuser = kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // drop the request stream and wait for every result
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // one register write
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // full set of registers
    task automatic configure(input logic link, input logic dyn, input logic [CNT_W-1:0] base,
                             input logic [CNT_W-1:0] per_credit, input logic [CNT_W-1:0] batch,
                             input logic [CNT_W-1:0] init, input logic [NVC_W-1:0] lanes);
        write_register(CFG_LINK_ENABLE, CNT_W'(link));
        write_register(CFG_DYNAMIC_MODE, CNT_W'(dyn));
        write_register(CFG_BASE_CREDIT, base);
        write_register(CFG_BYTES_PER_CR, per_credit);
        write_register(CFG_BATCH_SIZE, batch);
        write_register(CFG_INIT_CREDITS, init);
        write_register(CFG_NUM_VCS, CNT_W'(lanes));
    endtask

    // random traffic, mostly on a few peers so entries stay live
    task automatic run_random(input int count);
        logic [KIND_W-1:0] kind;
        logic [PEER_W-1:0] peer;
        logic [CNT_W-1:0]  size;
        logic [CNT_W-1:0]  amount;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                kind = KIND_ADD_PEER;
            else if (pick < 33)
                kind = KIND_CONSUME;
            else if (pick < 48)
                kind = KIND_CHECK;
            else if (pick < 63)
                kind = KIND_ADD_CREDITS;
            else if (pick < 83)
                kind = KIND_RECEIVE;
            else
                kind = KIND_CREDIT_RET;
            peer = PEER_W'(($urandom_range(99) < 75) ? $urandom_range(3)
                                                      : $urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 10)
                size = '0;
            else if (pick < 20)
                size = '1;
            else if (pick < 70)
                size = CNT_W'($urandom_range(4096));
            else
                size = CNT_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 10)
                amount = '0;
            else if (pick < 20)
                amount = '1;
            else if (pick < 70)
                amount = CNT_W'($urandom_range(1, 200));
            else
                amount = CNT_W'($urandom);
            send_request(kind, peer, VC_W'($urandom_range(3)), size, amount);
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, link off: invalid entries, disabled link
        send_request(KIND_ADD_CREDITS, 4'd0, 2'd0, 16'd0, 16'd0);
        send_request(KIND_CONSUME, 4'd0, 2'd0, 16'd0, 16'd0);
        send_request(KIND_CHECK, 4'd0, 2'd0, 16'hffff, 16'd0);
        send_request(KIND_RECEIVE, 4'd0, 2'd0, 16'd300, 16'd0);
        send_request(KIND_CREDIT_RET, 4'd0, 2'd0, 16'd0, 16'd0);
        // add peer with zero loads the initial credits
        send_request(KIND_ADD_PEER, 4'd1, 2'd0, 16'd0, 16'd0);
        send_request(KIND_CONSUME, 4'd1, 2'd0, 16'd0, 16'd0);
        send_request(KIND_CONSUME, 4'd1, 2'd1, 16'hffff, 16'd0);
        send_request(KIND_CHECK, 4'd1, 2'd2, 16'd5120, 16'd0);
        send_request(KIND_ADD_CREDITS, 4'd1, 2'd3, 16'd0, 16'hffff);
        send_request(KIND_SPARE_6, 4'd1, 2'd3, 16'd0, 16'd0);
        send_request(KIND_SPARE_7, 4'd15, 2'd3, 16'hffff, 16'hffff);
        wait_idle();

        // zero divisor, zero batch, one channel per peer
        configure(1'b1, 1'b1, 16'd1, 16'd0, 16'd0, 16'hffff, 3'd1);
        send_request(KIND_CREDIT_RET, 4'd14, 2'd0, 16'd0, 16'd0);
        send_request(KIND_RECEIVE, 4'd15, 2'd3, 16'hffff, 16'd0);
        send_request(KIND_RECEIVE, 4'd15, 2'd3, 16'd1, 16'd0);
        send_request(KIND_CREDIT_RET, 4'd15, 2'd3, 16'd0, 16'd0);
        send_request(KIND_ADD_PEER, 4'd2, 2'd0, 16'd0, 16'hffff);
        send_request(KIND_CONSUME, 4'd2, 2'd1, 16'd0, 16'd0);
        send_request(KIND_CONSUME, 4'd2, 2'd0, 16'hffff, 16'd0);
        send_request(KIND_CHECK, 4'd2, 2'd0, 16'd0, 16'd0);
        send_request(KIND_ADD_PEER, 4'd3, 2'd0, 16'd0, 16'd0);
        wait_idle();

        // fixed cost of zero grants on an empty entry
        configure(1'b1, 1'b0, 16'd0, 16'd1, 16'd1, 16'd20, 3'd4);
        send_request(KIND_CONSUME, 4'd2, 2'd0, 16'd1234, 16'd0);
        wait_idle();

        // random phases, sender idles little and receiver a lot
        configure(1'b1, 1'b1, 16'd1, 16'd256, 16'd1, 16'd20, 3'd4);
        run_random(300);
        wait_idle();
        configure(1'b1, 1'b0, 16'd3, 16'd64, 16'd8, 16'hffff, 3'd1);
        run_random(280);
        wait_idle();

        // roles swapped
        src_idle_pct = 58;
        sink_idle_pct = 12;
        configure(1'b0, 1'b1, 16'd0, 16'd1, 16'hffff, 16'd0, 3'd2);
        run_random(280);
        wait_idle();
        configure(1'b1, 1'b1, 16'hffff, 16'hffff, 16'd100, 16'd500, 3'd3);
        run_random(280);
        wait_idle();

        // no idling, long hold-off on the result side
        src_idle_pct = 0;
        sink_idle_pct = 0;
        configure(1'b1, 1'b1, 16'd2, 16'd37, 16'd0, 16'd1000, 3'd4);
        stall_trigger = 1'b1;
        run_random(280);
        wait_idle();
        configure(1'b1, 1'($urandom_range(1)), 16'($urandom_range(8)),
                  16'($urandom_range(1, 512)), 16'($urandom_range(50)),
                  16'($urandom_range(100)), 3'($urandom_range(1, 4)));
        run_random(200);
        wait_idle();

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
